@@ rtl/temp_press_hum_compensation_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation block
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef TEMP_PRESS_HUM_COMPENSATION_DEFINES_SVH
`define TEMP_PRESS_HUM_COMPENSATION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TPHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tphc_pkg.sv @@
// ----------------------------------------------------------------------------
// tphc_pkg
// Types and constants for the sensor compensation pipeline.
// ----------------------------------------------------------------------------
package tphc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_COEFFS  = 3'd0,
        REG_PRESS_LOW    = 3'd1,
        REG_PRESS_HIGH   = 3'd2,
        REG_PRESS_NINE   = 3'd3,
        REG_HUM_COEFFS   = 3'd4
    } cfg_reg_t;

    localparam logic [63:0] TFINE_OFFSET  = 64'd128000;
    localparam logic [63:0] PRESS_FULL    = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE   = 64'd3125;
    localparam logic [63:0] PRESS_BIAS    = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_OFFSET    = 32'd76800;
    localparam logic [31:0] HUM_MAX       = 32'd419430400;
    localparam logic [31:0] HUM_Y_BIAS    = 32'd2097152;
    localparam logic [31:0] HUM_X_ROUND   = 32'd16384;
    localparam logic [31:0] HUM_Y_ROUND   = 32'd8192;
    localparam logic [31:0] HUM_YB_BIAS   = 32'd32768;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temp_centideg;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic               pressure_invalid;
    } out_item_t;

endpackage

@@ rtl/temp_press_hum_compensation.sv @@
// ----------------------------------------------------------------------------
// temp_press_hum_compensation
// Integer compensation of raw pressure, temperature and humidity samples.
// ----------------------------------------------------------------------------
// channel | signals                       | direction | transaction
// in      | in_valid/in_ready/in_data     | sink      | one raw sample triple
// out     | out_valid/out_ready/out_data  | source    | one compensated result
// cfg     | cfg_valid/cfg_ready/cfg_index | sink      | one coefficient word
//         | cfg_data                      |           |
//
// One sample enters per cycle while the output is not stalled. The depth is
// set by the 64-stage pipelined pressure divider.
// Reset clears the valid bits and coefficient registers; no clearing pass.
// A stall at the output holds every stage at once; nothing is lost.
// ----------------------------------------------------------------------------
`include "temp_press_hum_compensation_defines.svh"

module temp_press_hum_compensation
    import tphc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ST_OUT = 84;

    // coefficient registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;
    logic [63:0] hum_coeffs_reg;

    logic [31:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    logic        en;
    logic        vld_reg [1:ST_OUT];

    logic [19:0] up_pipe_reg [1:9];
    logic [15:0] uh_pipe_reg [1:5];
    logic [31:0] ut32;

    // temperature
    logic [31:0] ta_reg, dd_reg, a_reg, b1_reg, tfine_reg;
    logic [31:0] temp_pipe_reg [4:ST_OUT];

    // pressure
    logic [63:0] v1_reg;
    logic [63:0] v1sq, v1p5, v1p2, v2a, v1b, v1e, num3125;
    logic [63:0] v1p5_pipe_reg [7:8];
    logic [63:0] v1p2_pipe_reg [7:8];
    logic [63:0] v2_reg, v1d_reg, tnum_reg, den_reg;
    logic [63:0] pp;
    logic [63:0] den_next;
    logic [63:0] quo;
    logic [63:0] ps;
    logic [63:0] m1, m8, m2;
    logic [63:0] ps_pipe_reg [79:80];
    logic [63:0] q_pipe_reg  [79:82];
    logic [63:0] m8_pipe_reg [81:82];
    logic [63:0] sum_reg;
    logic [63:0] press_next;
    logic [31:0] press_reg;
    logic        inv_pipe_reg [12:ST_OUT];

    // humidity
    logic [31:0] hh_reg, h5h_reg, hh6_reg, hh3_reg;
    logic [31:0] ya_reg, yb_reg, y0p_reg, y1_reg, y_reg, hm_reg;
    logic [31:0] x_pipe_reg  [6:9];
    logic [31:0] hm_pipe_reg [11:12];
    logic [31:0] ss_reg, sh_reg;
    logic [31:0] hs, hf, hcl;
    logic [16:0] hout_pipe_reg [13:ST_OUT];

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
            hum_coeffs_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                REG_HUM_COEFFS:  hum_coeffs_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign t1 = {16'd0, temp_coeffs_reg[15:0]};
    assign t2 = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3 = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};

    assign p1 = {48'd0, press_low_reg[15:0]};
    assign p2 = {{48{press_low_reg[31]}}, press_low_reg[31:16]};
    assign p3 = {{48{press_low_reg[47]}}, press_low_reg[47:32]};
    assign p4 = {{48{press_low_reg[63]}}, press_low_reg[63:48]};
    assign p5 = {{48{press_high_reg[15]}}, press_high_reg[15:0]};
    assign p6 = {{48{press_high_reg[31]}}, press_high_reg[31:16]};
    assign p7 = {{48{press_high_reg[47]}}, press_high_reg[47:32]};
    assign p8 = {{48{press_high_reg[63]}}, press_high_reg[63:48]};
    assign p9 = {{48{press_nine_reg[15]}}, press_nine_reg};

    assign h1 = {24'd0, hum_coeffs_reg[7:0]};
    assign h2 = {{16{hum_coeffs_reg[23]}}, hum_coeffs_reg[23:8]};
    assign h3 = {24'd0, hum_coeffs_reg[31:24]};
    assign h4 = {{20{hum_coeffs_reg[43]}}, hum_coeffs_reg[43:32]};
    assign h5 = {{20{hum_coeffs_reg[55]}}, hum_coeffs_reg[55:44]};
    assign h6 = {{24{hum_coeffs_reg[63]}}, hum_coeffs_reg[63:56]};

    // ------------------------------------------------------------------------
    // flow control: the whole pipeline advances together
    // ------------------------------------------------------------------------
    assign en       = !vld_reg[ST_OUT] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= ST_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= ST_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // arithmetic units
    // ------------------------------------------------------------------------
    tphc_mul64 u_mul_v1sq (.clk(clk), .en(en), .a(v1_reg), .b(v1_reg), .p(v1sq));
    tphc_mul64 u_mul_v1p5 (.clk(clk), .en(en), .a(v1_reg), .b(p5),     .p(v1p5));
    tphc_mul64 u_mul_v1p2 (.clk(clk), .en(en), .a(v1_reg), .b(p2),     .p(v1p2));
    tphc_mul64 u_mul_v2a  (.clk(clk), .en(en), .a(v1sq),   .b(p6),     .p(v2a));
    tphc_mul64 u_mul_v1b  (.clk(clk), .en(en), .a(v1sq),   .b(p3),     .p(v1b));
    tphc_mul64 u_mul_v1e  (.clk(clk), .en(en), .a(v1d_reg), .b(p1),    .p(v1e));
    tphc_mul64 u_mul_num  (.clk(clk), .en(en), .a(tnum_reg), .b(PRESS_SCALE),
                           .p(num3125));

    assign den_next = 64'($signed(v1e) >>> 33);

    tphc_div64 u_div (.clk(clk), .en(en), .num(num3125), .den(den_reg), .quo(quo));

    assign ps = 64'($signed(quo) >>> 13);

    tphc_mul64 u_mul_m1 (.clk(clk), .en(en), .a(p9), .b(ps), .p(m1));
    tphc_mul64 u_mul_m8 (.clk(clk), .en(en), .a(p8), .b(quo), .p(m8));
    tphc_mul64 u_mul_m2 (.clk(clk), .en(en), .a(m1), .b(ps_pipe_reg[80]), .p(m2));

    assign ut32 = {12'd0, in_data.raw_temperature};
    assign pp   = PRESS_FULL - {44'd0, up_pipe_reg[9]};

    assign press_next = 64'($signed(sum_reg) >>> 8) + (p7 << 4);

    assign hs  = 32'($signed(hm_reg) >>> 15);
    assign hf  = hm_pipe_reg[12] - 32'($signed(sh_reg) >>> 4);
    assign hcl = hf[31] ? 32'd0 : ((hf > HUM_MAX) ? HUM_MAX : hf);

    // ------------------------------------------------------------------------
    // datapath stages
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // raw sample delay lines
            up_pipe_reg[1] <= in_data.raw_pressure;
            uh_pipe_reg[1] <= in_data.raw_humidity;
            for (int k = 2; k <= 9; k++)
            begin
                up_pipe_reg[k] <= up_pipe_reg[k-1];
            end
            for (int k = 2; k <= 5; k++)
            begin
                uh_pipe_reg[k] <= uh_pipe_reg[k-1];
            end

            // temperature
            ta_reg    <= ((ut32 >> 3) - (t1 << 1)) * t2;
            dd_reg    <= ((ut32 >> 4) - t1) * ((ut32 >> 4) - t1);
            a_reg     <= 32'($signed(ta_reg) >>> 11);
            b1_reg    <= 32'($signed(dd_reg) >>> 12) * t3;
            tfine_reg <= a_reg + 32'($signed(b1_reg) >>> 14);
            temp_pipe_reg[4] <= 32'($signed(tfine_reg * 32'd5 + 32'd128) >>> 8);
            for (int k = 5; k <= ST_OUT; k++)
            begin
                temp_pipe_reg[k] <= temp_pipe_reg[k-1];
            end

            // pressure, ahead of the divider
            v1_reg <= {{32{tfine_reg[31]}}, tfine_reg} - TFINE_OFFSET;
            v1p5_pipe_reg[7] <= v1p5;
            v1p5_pipe_reg[8] <= v1p5_pipe_reg[7];
            v1p2_pipe_reg[7] <= v1p2;
            v1p2_pipe_reg[8] <= v1p2_pipe_reg[7];
            v2_reg   <= v2a + (v1p5_pipe_reg[8] << 17) + (p4 << 35);
            v1d_reg  <= PRESS_BIAS + 64'($signed(v1b) >>> 8) + (v1p2_pipe_reg[8] << 12);
            tnum_reg <= (pp << 31) - v2_reg;
            den_reg  <= den_next;
            inv_pipe_reg[12] <= (den_next == 64'd0);
            for (int k = 13; k <= ST_OUT; k++)
            begin
                inv_pipe_reg[k] <= inv_pipe_reg[k-1];
            end

            // pressure, after the divider
            ps_pipe_reg[79] <= ps;
            ps_pipe_reg[80] <= ps_pipe_reg[79];
            q_pipe_reg[79]  <= quo;
            for (int k = 80; k <= 82; k++)
            begin
                q_pipe_reg[k] <= q_pipe_reg[k-1];
            end
            m8_pipe_reg[81] <= m8;
            m8_pipe_reg[82] <= m8_pipe_reg[81];
            sum_reg <= q_pipe_reg[82] + 64'($signed(m2) >>> 25)
                       + 64'($signed(m8_pipe_reg[82]) >>> 19);
            // drop the value when the divisor was zero
            press_reg <= inv_pipe_reg[83] ? 32'd0 : press_next[31:0];

            // humidity
            hh_reg  <= tfine_reg - HUM_OFFSET;
            h5h_reg <= h5 * hh_reg;
            hh6_reg <= hh_reg * h6;
            hh3_reg <= hh_reg * h3;
            x_pipe_reg[6] <= 32'($signed(({16'd0, uh_pipe_reg[5]} << 14) - (h4 << 20)
                             - h5h_reg + HUM_X_ROUND) >>> 15);
            for (int k = 7; k <= 9; k++)
            begin
                x_pipe_reg[k] <= x_pipe_reg[k-1];
            end
            ya_reg  <= 32'($signed(hh6_reg) >>> 10);
            yb_reg  <= 32'($signed(hh3_reg) >>> 11) + HUM_YB_BIAS;
            y0p_reg <= ya_reg * yb_reg;
            y1_reg  <= (32'($signed(y0p_reg) >>> 10) + HUM_Y_BIAS) * h2;
            y_reg   <= 32'($signed(y1_reg + HUM_Y_ROUND) >>> 14);
            hm_reg  <= x_pipe_reg[9] * y_reg;
            ss_reg  <= hs * hs;
            hm_pipe_reg[11] <= hm_reg;
            hm_pipe_reg[12] <= hm_pipe_reg[11];
            sh_reg  <= 32'($signed(ss_reg) >>> 7) * h1;
            hout_pipe_reg[13] <= hcl[28:12];
            for (int k = 14; k <= ST_OUT; k++)
            begin
                hout_pipe_reg[k] <= hout_pipe_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // output
    // ------------------------------------------------------------------------
    assign out_valid                 = vld_reg[ST_OUT];
    assign out_data.temp_centideg    = temp_pipe_reg[ST_OUT];
    assign out_data.pressure_q24_8   = press_reg;
    assign out_data.humidity_q22_10  = hout_pipe_reg[ST_OUT];
    assign out_data.pressure_invalid = inv_pipe_reg[ST_OUT];

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    `TPHC_ASSERT_NOW(a_inv_zero, out_valid && out_data.pressure_invalid,
        out_data.pressure_q24_8 == 32'd0, "pressure not zero on invalid divisor")
    `TPHC_ASSERT_NOW(a_hum_clamp, out_valid,
        out_data.humidity_q22_10 <= 17'd102400, "humidity above clamp")
    `TPHC_ASSERT_NOW(a_stall_src, in_valid && !in_ready,
        out_valid && !out_ready, "input stalled without output backpressure")
    `TPHC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && ($stable(out_data.temp_centideg) || $past(in_ready)),
        "stalled stage advanced")

endmodule

@@ rtl/tphc_mul64.sv @@
// ----------------------------------------------------------------------------
// tphc_mul64
// Two-stage 64x64 multiply, low 64 bits of the product (wraps).
// ----------------------------------------------------------------------------
module tphc_mul64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] ll_reg;
    logic [31:0] hl_reg;
    logic [31:0] lh_reg;
    logic [63:0] p_reg;

    // partial products: only the low half of the cross terms survives the wrap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            hl_reg <= a[63:32] * b[31:0];
            lh_reg <= a[31:0] * b[63:32];
            p_reg  <= ll_reg + {hl_reg + lh_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

@@ rtl/tphc_div64.sv @@
// ----------------------------------------------------------------------------
// tphc_div64
// Pipelined signed 64-bit division, truncating toward zero, one quotient
// bit per stage. A zero divisor gives a don't-care.
// ----------------------------------------------------------------------------
module tphc_div64 (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [63:0] quo
);

    localparam int STEPS = 64;

    logic [63:0] rem_reg [0:STEPS];
    logic [63:0] qt_reg  [0:STEPS];
    logic [63:0] dv_reg  [0:STEPS];
    logic        ng_reg  [0:STEPS];
    logic [63:0] rem_next [1:STEPS];
    logic [63:0] qt_next  [1:STEPS];
    logic [63:0] quo_reg;

    always_comb
    begin
        for (int k = 1; k <= STEPS; k++)
        begin
            logic [64:0] r2;
            logic        ge;
            r2 = {rem_reg[k-1], qt_reg[k-1][63]};
            ge = (r2 >= {1'b0, dv_reg[k-1]});
            rem_next[k] = ge ? 64'(r2 - {1'b0, dv_reg[k-1]}) : r2[63:0];
            qt_next[k]  = {qt_reg[k-1][62:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            qt_reg[0]  <= num[63] ? 64'(-num) : num;
            dv_reg[0]  <= den[63] ? 64'(-den) : den;
            ng_reg[0]  <= num[63] ^ den[63];
            for (int k = 1; k <= STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                qt_reg[k]  <= qt_next[k];
                dv_reg[k]  <= dv_reg[k-1];
                ng_reg[k]  <= ng_reg[k-1];
            end
            quo_reg <= ng_reg[STEPS] ? 64'(-qt_reg[STEPS]) : qt_reg[STEPS];
        end
    end

    assign quo = quo_reg;

endmodule

@@ sim/temp_press_hum_compensation_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_press_hum_compensation_tb
// Drives raw sample triples through the compensation pipeline under several
// calibration sets. Compensated results are checked field by field, in order,
// against an in-bench integer model of the temperature, pressure and
// humidity formulas. Random idling is applied on both sides of the block.
// ----------------------------------------------------------------------------
module temp_press_hum_compensation_tb;
    import tphc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int DRAIN_CYCLES   = 120;
    localparam int WATCHDOG_LIMIT = 4000;

    // ------------------------------------------------------------------------
    // Scoreboard: calibration copy, expected results in arrival order
    // ------------------------------------------------------------------------
    class comp_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_cal_lo;
        logic [63:0] press_cal_hi;
        logic [15:0] press_cal_nine;
        logic [63:0] hum_cal;
        out_item_t   pending_results[$];

        function new();
            temp_cal       = '0;
            press_cal_lo   = '0;
            press_cal_hi   = '0;
            press_cal_nine = '0;
            hum_cal        = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TEMP_COEFFS: temp_cal       = val[47:0];
                REG_PRESS_LOW:   press_cal_lo   = val;
                REG_PRESS_HIGH:  press_cal_hi   = val;
                REG_PRESS_NINE:  press_cal_nine = val[15:0];
                REG_HUM_COEFFS:  hum_cal        = val;
                default: ;
            endcase
        endfunction

        function out_item_t compensate(in_item_t s);
            out_item_t   r;
            logic [31:0] ut, uh, t1, t2, t3, a, d, b, tf, m;
            logic [31:0] h1, h2, h3, h4, h5, h6, h, x, y, y1, y2, sq;
            logic [63:0] up, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic [63:0] v1, v2, w, p, ps, num, an, ad, q;

            ut = {12'd0, s.raw_temperature};
            uh = {16'd0, s.raw_humidity};
            up = {44'd0, s.raw_pressure};
            t1 = {16'd0, temp_cal[15:0]};
            t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
            t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
            p1 = {48'd0, press_cal_lo[15:0]};
            p2 = {{48{press_cal_lo[31]}}, press_cal_lo[31:16]};
            p3 = {{48{press_cal_lo[47]}}, press_cal_lo[47:32]};
            p4 = {{48{press_cal_lo[63]}}, press_cal_lo[63:48]};
            p5 = {{48{press_cal_hi[15]}}, press_cal_hi[15:0]};
            p6 = {{48{press_cal_hi[31]}}, press_cal_hi[31:16]};
            p7 = {{48{press_cal_hi[47]}}, press_cal_hi[47:32]};
            p8 = {{48{press_cal_hi[63]}}, press_cal_hi[63:48]};
            p9 = {{48{press_cal_nine[15]}}, press_cal_nine};
            h1 = {24'd0, hum_cal[7:0]};
            h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
            h3 = {24'd0, hum_cal[31:24]};
            h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
            h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
            h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};

            // temperature, wrapping 32-bit
            m  = ((ut >> 3) - (t1 << 1)) * t2;
            a  = $signed(m) >>> 11;
            d  = (ut >> 4) - t1;
            m  = d * d;
            m  = $signed(m) >>> 12;
            m  = m * t3;
            b  = $signed(m) >>> 14;
            tf = a + b;
            m  = tf * 32'd5 + 32'd128;
            r.temp_centideg = $signed(m) >>> 8;

            // pressure, wrapping 64-bit
            r.pressure_q24_8   = '0;
            r.pressure_invalid = 1'b0;
            v1 = {{32{tf[31]}}, tf} - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            w  = v1 * v1 * p3;
            w  = $signed(w) >>> 8;
            v1 = w + ((v1 * p2) << 12);
            w  = (64'h0000_8000_0000_0000 + v1) * p1;
            v1 = $signed(w) >>> 33;
            if (v1 == 64'd0)
            begin
                r.pressure_invalid = 1'b1;
            end
            else
            begin
                p   = 64'd1048576 - up;
                num = ((p << 31) - v2) * 64'd3125;
                an  = num[63] ? -num : num;
                ad  = v1[63] ? -v1 : v1;
                q   = an / ad;
                p   = (num[63] != v1[63]) ? -q : q;
                ps  = $signed(p) >>> 13;
                w   = p9 * ps * ps;
                v1  = $signed(w) >>> 25;
                w   = p8 * p;
                v2  = $signed(w) >>> 19;
                w   = p + v1 + v2;
                w   = $signed(w) >>> 8;
                p   = w + (p7 << 4);
                r.pressure_q24_8 = p[31:0];
            end

            // humidity, wrapping 32-bit
            h  = tf - 32'd76800;
            m  = (uh << 14) - (h4 << 20) - h5 * h + 32'd16384;
            x  = $signed(m) >>> 15;
            m  = h * h6;
            y1 = $signed(m) >>> 10;
            m  = h * h3;
            y2 = $signed(m) >>> 11;
            y2 = y2 + 32'd32768;
            m  = y1 * y2;
            y  = $signed(m) >>> 10;
            m  = (y + 32'd2097152) * h2 + 32'd8192;
            y  = $signed(m) >>> 14;
            h  = x * y;
            sq = $signed(h) >>> 15;
            m  = sq * sq;
            m  = $signed(m) >>> 7;
            m  = m * h1;
            m  = $signed(m) >>> 4;
            h  = h - m;
            if (h[31])
                h = 32'd0;
            else if (h > 32'd419430400)
                h = 32'd419430400;
            r.humidity_q22_10 = h[28:12];
            return r;
        endfunction

        function void note_sample(in_item_t s);
            pending_results.push_back(compensate(s));
        endfunction

        // returns an empty string when the result matches
        function string check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_results.size() == 0)
                return $sformatf("unexpected result %h", got);
            exp_r = pending_results.pop_front();
            if (got.temp_centideg !== exp_r.temp_centideg)
                return $sformatf("temp_centideg got %0d exp %0d",
                                 got.temp_centideg, exp_r.temp_centideg);
            if (got.pressure_q24_8 !== exp_r.pressure_q24_8)
                return $sformatf("pressure_q24_8 got %h exp %h",
                                 got.pressure_q24_8, exp_r.pressure_q24_8);
            if (got.humidity_q22_10 !== exp_r.humidity_q22_10)
                return $sformatf("humidity_q22_10 got %h exp %h",
                                 got.humidity_q22_10, exp_r.humidity_q22_10);
            if (got.pressure_invalid !== exp_r.pressure_invalid)
                return $sformatf("pressure_invalid got %b exp %b",
                                 got.pressure_invalid, exp_r.pressure_invalid);
            return "";
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    comp_scoreboard sb;
    int             mismatch_count;
    int             idle_cycles;
    bit             quiet_phase;

    temp_press_hum_compensation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_calibration(logic [47:0] tc, logic [63:0] plo, logic [63:0] phi,
                                    logic [15:0] p9, logic [63:0] hc);
        write_reg(REG_TEMP_COEFFS, {16'hA5A5, tc});
        write_reg(REG_PRESS_LOW, plo);
        write_reg(REG_PRESS_HIGH, phi);
        write_reg(REG_PRESS_NINE, {48'hFFFF_0000_FFFF, p9});
        write_reg(REG_HUM_COEFFS, hc);
    endtask

    task automatic send_sample(in_item_t s);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        sb.note_sample(s);
    endtask

    task automatic send_random(int count);
        in_item_t s;
        for (int i = 0; i < count; i++)
        begin
            s.raw_pressure    = 20'($urandom);
            s.raw_temperature = 20'($urandom);
            s.raw_humidity    = 16'($urandom);
            // lean toward the typical working range most of the time
            if ($urandom_range(0, 3) != 0)
            begin
                s.raw_temperature = 20'($urandom_range(400000, 600000));
                s.raw_pressure    = 20'($urandom_range(250000, 450000));
            end
            send_sample(s);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_directed();
        send_sample('{raw_pressure: 20'd0,      raw_temperature: 20'd0,
                      raw_humidity: 16'd0});
        send_sample('{raw_pressure: 20'hFFFFF,  raw_temperature: 20'hFFFFF,
                      raw_humidity: 16'hFFFF});
        send_sample('{raw_pressure: 20'hAAAAA,  raw_temperature: 20'h55555,
                      raw_humidity: 16'hAAAA});
        send_sample('{raw_pressure: 20'h55555,  raw_temperature: 20'hAAAAA,
                      raw_humidity: 16'h5555});
        send_sample('{raw_pressure: 20'd415148, raw_temperature: 20'd519888,
                      raw_humidity: 16'd30000});
        send_sample('{raw_pressure: 20'hFFFFF,  raw_temperature: 20'd0,
                      raw_humidity: 16'd0});
    endtask

    // result side: random stall per result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = sb.check_result(out_data);
            if (msg != "")
                report(msg);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        sb             = new();
        mismatch_count = 0;
        idle_cycles    = 0;
        quiet_phase    = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration: zero divisor on every sample
        send_directed();
        send_random(80);
        drain_results();

        // typical factory calibration
        load_calibration({16'hFC18, 16'd26435, 16'd27504},
                         {16'd2855, 16'd3024, 16'hD843, 16'd36477},
                         {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                         16'd6000,
                         {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75});
        send_directed();
        send_random(100);
        // hold the sender until the pipeline has emptied
        drain_results();
        send_random(150);
        drain_results();

        // all ones, no idling on either side
        quiet_phase = 1'b1;
        load_calibration('1, '1, '1, '1, '1);
        send_directed();
        send_random(230);
        drain_results();
        quiet_phase = 1'b0;

        // most negative signed coefficients
        load_calibration(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                         64'h8000_8000_8000_8000, 16'h8000,
                         64'h8080_0800_FF80_00FF);
        send_directed();
        send_random(230);
        drain_results();

        // random calibrations, plus a write to an unused index
        for (int k = 0; k < 3; k++)
        begin
            load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                             {$urandom, $urandom}, 16'($urandom),
                             {$urandom, $urandom});
            write_reg(CFG_UNUSED_IDX, {$urandom, $urandom});
            send_random(170);
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_results.size() != 0)
            report($sformatf("%0d results never arrived", sb.pending_results.size()));
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ temp_press_hum_compensation.f @@
+incdir+rtl
rtl/tphc_pkg.sv
rtl/tphc_mul64.sv
rtl/tphc_div64.sv
rtl/temp_press_hum_compensation.sv
sim/temp_press_hum_compensation_tb.sv
